// ----- sv/ustc_pkg.sv -----
// ============================================================================
// ustc_pkg: shared types and constants for the Unix time to calendar pipeline
// Holds field widths, stage counts, division constants and the month table.
// ============================================================================
package ustc_pkg;

    // Field widths
    localparam int UNIX_W   = 38;
    localparam int OFFSET_W = 17;
    localparam int LOCAL_W  = 39;
    localparam int DAYS_W   = 22;
    localparam int SECS_W   = 17;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int TDATA_W  = 40;

    // Pipeline shape
    localparam int SPLIT_STAGES = 4;
    localparam int DATE_STAGES  = 9;
    localparam int TOD_CALC     = 3;
    localparam int TOD_DELAY    = DATE_STAGES - TOD_CALC;
    localparam int NUM_STAGES   = SPLIT_STAGES + DATE_STAGES + 1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd7200;

    // First local second of year 10000
    localparam logic [LOCAL_W-1:0] LIMIT_SECS = 39'd253402300800;

    // 86400 = 128 * 675; quotient by 675 is estimated then corrected once
    localparam logic [9:0]  DAY_ODD   = 10'd675;
    localparam logic [22:0] MAGIC_675 = 23'((64'd1 << 32) / 64'd675);

    // Exact reciprocal constants: ceil(2^k / d) with k = n + ceil(log2 d)
    localparam logic [13:0] MAGIC_225  = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
    localparam logic [10:0] MAGIC_15   = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
    localparam logic [22:0] MAGIC_ERA  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [18:0] MAGIC_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] MAGIC_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  MAGIC_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] MAGIC_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // Days from 0000-03-01 to 1970-01-01
    localparam logic [DAYS_W-1:0] EPOCH_SHIFT = 22'd719468;
    localparam logic [17:0]       DAYS_400Y   = 18'd146097;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SECS_W-1:0] secs;
        logic              oor;
    } split_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               oor;
    } date_t;

    // Day of March-based year on which month index mp starts: (153*mp+2)/5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] ms;
        begin
            case (mp)
                4'd0:    ms = 9'd0;
                4'd1:    ms = 9'd31;
                4'd2:    ms = 9'd61;
                4'd3:    ms = 9'd92;
                4'd4:    ms = 9'd122;
                4'd5:    ms = 9'd153;
                4'd6:    ms = 9'd184;
                4'd7:    ms = 9'd214;
                4'd8:    ms = 9'd245;
                4'd9:    ms = 9'd275;
                4'd10:   ms = 9'd306;
                4'd11:   ms = 9'd337;
                default: ms = 9'd0;
            endcase
            return ms;
        end
    endfunction

endpackage

// ----- sv/ustc_day_split.sv -----
// ============================================================================
// ustc_day_split: local time, range check and day / second-of-day split
// Four stages: offset add and clamp, reciprocal multiply, back-multiply,
// remainder correction.
// ============================================================================
module ustc_day_split
(
    input  logic                                clk,
    input  logic [ustc_pkg::SPLIT_STAGES-1:0]   adv,
    input  logic [ustc_pkg::UNIX_W-1:0]         unix_seconds,
    input  logic [ustc_pkg::OFFSET_W-1:0]       utc_offset_seconds,
    output ustc_pkg::split_t                    split_out
);

    logic [39:0]                  sum_c;
    logic [ustc_pkg::LOCAL_W-1:0] local_c;
    logic [ustc_pkg::LOCAL_W-1:0] local_reg;
    logic                         oor0_reg;

    logic [31:0]                  q1_c;
    logic [54:0]                  p1_c;
    logic [ustc_pkg::DAYS_W-1:0]  qe1_reg;
    logic [31:0]                  q1_1_reg;
    logic [6:0]                   r1_1_reg;
    logic                         oor1_reg;

    logic [31:0]                  prod2_c;
    logic [31:0]                  prod2_reg;
    logic [ustc_pkg::DAYS_W-1:0]  qe2_reg;
    logic [31:0]                  q1_2_reg;
    logic [6:0]                   r1_2_reg;
    logic                         oor2_reg;

    logic [31:0]                  diff3_c;
    logic [10:0]                  rem3_c;
    logic                         fix3_c;
    logic [10:0]                  rem3_fixed_c;
    ustc_pkg::split_t             split_next;
    ustc_pkg::split_t             split_reg;

    // Stage 0: add the signed offset, clamp below zero
    assign sum_c   = {2'b00, unix_seconds}
                   + {{(40 - ustc_pkg::OFFSET_W){utc_offset_seconds[ustc_pkg::OFFSET_W-1]}},
                      utc_offset_seconds};
    assign local_c = sum_c[39] ? '0 : sum_c[ustc_pkg::LOCAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            local_reg <= local_c;
            oor0_reg  <= (local_c >= ustc_pkg::LIMIT_SECS);
        end
    end

    // Stage 1: estimate (local >> 7) / 675, low by at most one
    assign q1_c = local_reg[ustc_pkg::LOCAL_W-1:7];
    assign p1_c = 55'(q1_c) * 55'(ustc_pkg::MAGIC_675);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            qe1_reg  <= p1_c[53:32];
            q1_1_reg <= q1_c;
            r1_1_reg <= local_reg[6:0];
            oor1_reg <= oor0_reg;
        end
    end

    // Stage 2: multiply the estimate back
    assign prod2_c = 32'(qe1_reg) * 32'(ustc_pkg::DAY_ODD);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            prod2_reg <= prod2_c;
            qe2_reg   <= qe1_reg;
            q1_2_reg  <= q1_1_reg;
            r1_2_reg  <= r1_1_reg;
            oor2_reg  <= oor1_reg;
        end
    end

    // Stage 3: remainder below 1350, correct once
    assign diff3_c      = q1_2_reg - prod2_reg;
    assign rem3_c       = diff3_c[10:0];
    assign fix3_c       = (rem3_c >= 11'(ustc_pkg::DAY_ODD));
    assign rem3_fixed_c = fix3_c ? (rem3_c - 11'(ustc_pkg::DAY_ODD)) : rem3_c;

    always_comb
    begin
        split_next.days = qe2_reg + ustc_pkg::DAYS_W'(fix3_c);
        split_next.secs = {rem3_fixed_c[9:0], r1_2_reg};
        split_next.oor  = oor2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            split_reg <= split_next;
        end
    end

    assign split_out = split_reg;

endmodule

// ----- sv/ustc_time_of_day.sv -----
// ============================================================================
// ustc_time_of_day: hour and minute from the second of the day
// Three compute stages, then a delay line that lines up with the date path.
// ============================================================================
module ustc_time_of_day
(
    input  logic                               clk,
    input  logic [ustc_pkg::DATE_STAGES-1:0]   adv,
    input  logic [ustc_pkg::SECS_W-1:0]        secs,
    output ustc_pkg::tod_t                     tod_out
);

    logic [12:0]                   t0_c;
    logic [26:0]                   ph0_c;
    logic [ustc_pkg::HOUR_W-1:0]   h0_reg;
    logic [12:0]                   t0_reg;
    logic [3:0]                    lo0_reg;

    logic [12:0]                   rem1_c;
    logic [ustc_pkg::HOUR_W-1:0]   h1_reg;
    logic [11:0]                   mm1_reg;

    logic [20:0]                   pm2_c;
    ustc_pkg::tod_t                tod2_next;
    ustc_pkg::tod_t                tod2_reg;

    ustc_pkg::tod_t                dly_reg [ustc_pkg::TOD_DELAY];

    // Stage 0: hour = (secs >> 4) / 225
    assign t0_c  = secs[ustc_pkg::SECS_W-1:4];
    assign ph0_c = 27'(t0_c) * 27'(ustc_pkg::MAGIC_225);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h0_reg  <= ph0_c[25:21];
            t0_reg  <= t0_c;
            lo0_reg <= secs[3:0];
        end
    end

    // Stage 1: seconds within the hour
    assign rem1_c = t0_reg - 13'(h0_reg) * 13'd225;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            h1_reg  <= h0_reg;
            mm1_reg <= {rem1_c[7:0], lo0_reg};
        end
    end

    // Stage 2: minute = (sec_of_hour >> 2) / 15
    assign pm2_c = 21'(mm1_reg[11:2]) * 21'(ustc_pkg::MAGIC_15);

    always_comb
    begin
        tod2_next.hour   = h1_reg;
        tod2_next.minute = pm2_c[19:14];
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            tod2_reg <= tod2_next;
        end
    end

    // Hold results in step with the date path
    always_ff @(posedge clk)
    begin
        if (adv[ustc_pkg::TOD_CALC])
        begin
            dly_reg[0] <= tod2_reg;
        end
        for (int i = 1; i < ustc_pkg::TOD_DELAY; i++)
        begin
            if (adv[ustc_pkg::TOD_CALC + i])
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign tod_out = dly_reg[ustc_pkg::TOD_DELAY-1];

endmodule

// ----- sv/ustc_civil_date.sv -----
// ============================================================================
// ustc_civil_date: Gregorian year, month and day from days since 1970
// Nine stages over a March-based 400-year era decomposition.
// ============================================================================
module ustc_civil_date
(
    input  logic                               clk,
    input  logic [ustc_pkg::DATE_STAGES-1:0]   adv,
    input  logic [ustc_pkg::DAYS_W-1:0]        days,
    input  logic                               oor,
    output ustc_pkg::date_t                    date_out
);

    logic                          oor_reg [ustc_pkg::DATE_STAGES-1];

    logic [ustc_pkg::DAYS_W-1:0]   z0_reg;

    logic [44:0]                   pe1_c;
    logic [4:0]                    era1_reg;
    logic [ustc_pkg::DAYS_W-1:0]   z1_reg;

    logic [ustc_pkg::DAYS_W-1:0]   doe2_c;
    logic [4:0]                    era2_reg;
    logic [17:0]                   doe2_reg;

    logic [36:0]                   pa3_c;
    logic [2:0]                    b3_c;
    logic [17:0]                   num3_c;
    logic [4:0]                    era3_reg;
    logic [17:0]                   doe3_reg;
    logic [17:0]                   num3_reg;

    logic [36:0]                   py4_c;
    logic [4:0]                    era4_reg;
    logic [17:0]                   doe4_reg;
    logic [8:0]                    yoe4_reg;

    logic [18:0]                   pc5_c;
    logic [4:0]                    era5_reg;
    logic [17:0]                   doe5_reg;
    logic [8:0]                    yoe5_reg;
    logic [17:0]                   base5_reg;
    logic [2:0]                    c5_reg;

    logic [17:0]                   doy6_c;
    logic [8:0]                    doy6_reg;
    logic [ustc_pkg::YEAR_W-1:0]   y6_reg;

    logic [10:0]                   x7_c;
    logic [22:0]                   pmp7_c;
    logic [3:0]                    mp7_reg;
    logic [8:0]                    doy7_reg;
    logic [ustc_pkg::YEAR_W-1:0]   y7_reg;

    logic [8:0]                    dd8_c;
    logic                          late8_c;
    ustc_pkg::date_t               date_next;
    ustc_pkg::date_t               date_reg;

    // Carry the range flag beside the data
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            oor_reg[0] <= oor;
        end
        for (int i = 1; i < ustc_pkg::DATE_STAGES - 1; i++)
        begin
            if (adv[i])
            begin
                oor_reg[i] <= oor_reg[i-1];
            end
        end
    end

    // Stage 0: shift to days since 0000-03-01
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            z0_reg <= days + ustc_pkg::EPOCH_SHIFT;
        end
    end

    // Stage 1: 400-year era
    assign pe1_c = 45'(z0_reg) * 45'(ustc_pkg::MAGIC_ERA);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            era1_reg <= pe1_c[44:40];
            z1_reg   <= z0_reg;
        end
    end

    // Stage 2: day of era
    assign doe2_c = z1_reg - ustc_pkg::DAYS_W'(era1_reg) * ustc_pkg::DAYS_W'(ustc_pkg::DAYS_400Y);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            era2_reg <= era1_reg;
            doe2_reg <= doe2_c[17:0];
        end
    end

    // Stage 3: drop leap days of the era before dividing by 365
    assign pa3_c  = 37'(doe2_reg) * 37'(ustc_pkg::MAGIC_1460);
    assign b3_c   = 3'(doe2_reg >= 18'd36524) + 3'(doe2_reg >= 18'd73048)
                  + 3'(doe2_reg >= 18'd109572) + 3'(doe2_reg >= 18'd146096);
    assign num3_c = doe2_reg - 18'(pa3_c[35:29]) + 18'(b3_c)
                  - 18'(doe2_reg == 18'd146096);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            era3_reg <= era2_reg;
            doe3_reg <= doe2_reg;
            num3_reg <= num3_c;
        end
    end

    // Stage 4: year of era
    assign py4_c = 37'(num3_reg) * 37'(ustc_pkg::MAGIC_365);

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            era4_reg <= era3_reg;
            doe4_reg <= doe3_reg;
            yoe4_reg <= py4_c[35:27];
        end
    end

    // Stage 5: days before the year, without the century correction
    assign pc5_c = 19'(yoe4_reg) * 19'(ustc_pkg::MAGIC_100);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            era5_reg  <= era4_reg;
            doe5_reg  <= doe4_reg;
            yoe5_reg  <= yoe4_reg;
            base5_reg <= 18'(yoe4_reg) * 18'd365 + 18'(yoe4_reg[8:2]);
            c5_reg    <= pc5_c[18:16];
        end
    end

    // Stage 6: day of March-based year and full year
    assign doy6_c = doe5_reg - base5_reg + 18'(c5_reg);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            doy6_reg <= doy6_c[8:0];
            y6_reg   <= ustc_pkg::YEAR_W'(era5_reg) * ustc_pkg::YEAR_W'(400)
                      + ustc_pkg::YEAR_W'(yoe5_reg);
        end
    end

    // Stage 7: March-based month index
    assign x7_c   = 11'(doy6_reg) * 11'd5 + 11'd2;
    assign pmp7_c = 23'(x7_c) * 23'(ustc_pkg::MAGIC_153);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            mp7_reg  <= pmp7_c[22:19];
            doy7_reg <= doy6_reg;
            y7_reg   <= y6_reg;
        end
    end

    // Stage 8: calendar month, day, and year roll for January and February
    assign dd8_c   = doy7_reg - ustc_pkg::month_start(mp7_reg) + 9'd1;
    assign late8_c = (mp7_reg >= 4'd10);

    always_comb
    begin
        date_next.year  = y7_reg + ustc_pkg::YEAR_W'(late8_c);
        date_next.month = late8_c ? (mp7_reg - 4'd9) : (mp7_reg + 4'd3);
        date_next.day   = dd8_c[ustc_pkg::DAY_W-1:0];
        date_next.oor   = oor_reg[ustc_pkg::DATE_STAGES-2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            date_reg <= date_next;
        end
    end

    assign date_out = date_reg;

endmodule

// ----- sv/unix_seconds_to_calendar_top.sv -----
// Pipeline: 4 split stages, 9 date stages and the output register, in that order.
// Throughput: one item per cycle unless the result stream stalls on m_tready.
// Each stage advances when empty or when the stage after it advances.
// Reset (rst_n low, asynchronous): pipeline emptied, offset set to 7200 seconds.
// ============================================================================
// unix_seconds_to_calendar_top: Unix time to local calendar date and time
// Adds the UTC offset, splits into days and seconds, and decodes the
// Gregorian date and the time of day in parallel pipelines.
// ============================================================================
module unix_seconds_to_calendar_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Offset register write
    input  logic                              cfg_wr_en,
    input  logic [ustc_pkg::OFFSET_W-1:0]     cfg_wr_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ustc_pkg::TDATA_W-1:0]      s_tdata,   // [37:0] unix_seconds
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ustc_pkg::TDATA_W-1:0]      m_tdata,   // [13:0] year, [17:14] month,
                                                         // [22:18] day_of_month,
                                                         // [27:23] hour, [33:28] minute
    output logic                              m_tuser    // [0] out_of_range
);

    localparam int LAST = ustc_pkg::NUM_STAGES - 1;

    logic [ustc_pkg::OFFSET_W-1:0]   offset_reg;
    logic [ustc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [ustc_pkg::NUM_STAGES-1:0] adv;

    ustc_pkg::split_t                split_w;
    ustc_pkg::tod_t                  tod_w;
    ustc_pkg::date_t                 date_w;

    logic [ustc_pkg::TDATA_W-1:0]    tdata_next;
    logic [ustc_pkg::TDATA_W-1:0]    tdata_reg;
    logic                            tuser_reg;

    // Offset register; to be written only while the pipeline is idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= ustc_pkg::OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    // Advance a stage when it is empty or its successor advances; the last
    // stage advances when its transfer completes or it holds nothing
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < ustc_pkg::NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[0];

    ustc_day_split u_split
    (
        .clk                (clk),
        .adv                (adv[ustc_pkg::SPLIT_STAGES-1:0]),
        .unix_seconds       (s_tdata[ustc_pkg::UNIX_W-1:0]),
        .utc_offset_seconds (offset_reg),
        .split_out          (split_w)
    );

    ustc_time_of_day u_tod
    (
        .clk     (clk),
        .adv     (adv[LAST-1:ustc_pkg::SPLIT_STAGES]),
        .secs    (split_w.secs),
        .tod_out (tod_w)
    );

    ustc_civil_date u_date
    (
        .clk      (clk),
        .adv      (adv[LAST-1:ustc_pkg::SPLIT_STAGES]),
        .days     (split_w.days),
        .oor      (split_w.oor),
        .date_out (date_w)
    );

    // Output register: drop the date fields when out of range
    always_comb
    begin
        tdata_next = '0;
        if (!date_w.oor)
        begin
            tdata_next[13:0]  = date_w.year;
            tdata_next[17:14] = date_w.month;
            tdata_next[22:18] = date_w.day;
        end
        tdata_next[27:23] = tod_w.hour;
        tdata_next[33:28] = tod_w.minute;
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= date_w.oor;
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// ----- sv/ustc_checker.sv -----
// ============================================================================
// ustc_checker: port-level checks for the calendar pipeline
// Watches the result stream and the input handshake over time.
// ============================================================================
module ustc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ustc_pkg::TDATA_W-1:0]      m_tdata,
    input  logic                              m_tuser
);

    // A free output side never back-pressures the input
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    // Out-of-range results carry a zero date
    a_oor_zero_date: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[22:0] == 23'd0))
        else $error("date fields not zero on out-of-range result");

    // In-range results have a real month and day and a year from 1970 on
    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12)
                                    && (m_tdata[22:18] != 5'd0)
                                    && (m_tdata[13:0] >= 14'd1970)))
        else $error("month, day or year out of range");

    // Time of day always well formed
    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[27:23] <= 5'd23) && (m_tdata[33:28] <= 6'd59)))
        else $error("hour or minute out of range");

    // A stalled result holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind unix_seconds_to_calendar_top ustc_checker u_ustc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/testbench.sv -----
// ============================================================================
// testbench: self-checking bench for unix_seconds_to_calendar_top
// Drives Unix times through the input stream, predicts the local calendar
// date and time of day for each accepted transfer, and compares every result
// transfer field by field. A short table of hand-picked times runs first,
// then random phases under several UTC offsets with random idling on both
// streams and one long receiver hold-off that backs up the pipeline.
// ============================================================================
module testbench;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 195;
    localparam int IDLE_PERCENT   = 12;
    localparam int SETTLE_CYCLES  = ustc_pkg::NUM_STAGES + 4;

    localparam longint unsigned SECONDS_PER_DAY = 86400;
    localparam longint unsigned YEAR_10000_SECS = 64'd253402300800;
    localparam int unsigned     DAYS_PER_ERA    = 146097;

    // Offsets used by the phases: the stated range ends, zero, the reset value and
    // the two raw 17-bit extremes that lie outside the stated range
    localparam logic [16:0] OFF_HOME = ustc_pkg::OFFSET_RESET;
    localparam logic [16:0] OFF_UTC  = 17'd0;
    localparam logic [16:0] OFF_WEST = -17'sd43200;
    localparam logic [16:0] OFF_EAST = 17'd50400;
    localparam logic [16:0] OFF_MIN  = 17'h10000;
    localparam logic [16:0] OFF_MAX  = 17'h0FFFF;

    // One result transfer, unpacked from m_tdata and m_tuser
    typedef struct packed {
        logic [ustc_pkg::YEAR_W-1:0]   year;
        logic [ustc_pkg::MONTH_W-1:0]  month;
        logic [ustc_pkg::DAY_W-1:0]    day;
        logic [ustc_pkg::HOUR_W-1:0]   hour;
        logic [ustc_pkg::MINUTE_W-1:0] minute;
        logic                          oor;
    } civil_t;

    // One row of the directed table: offset in force, input time, and an
    // expected result typed in by hand when pinned is set
    typedef struct packed {
        logic [16:0] offset;
        logic [37:0] secs;
        logic        pinned;
        civil_t      want;
    } row_t;

    localparam int NUM_DIRECTED = 24;

    // Rows are grouped by offset; the offset register is rewritten only
    // where the offset changes from one row to the next.
    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        // reset offset: epoch lands at 02:00
        {OFF_HOME, 38'd0,            1'b1, {14'd1970, 4'd1, 5'd1, 5'd2, 6'd0, 1'b0}},
        {OFF_HOME, 38'h3F_FFFF_FFFF, 1'b0, 35'd0},
        // last minute before year 10000, then the first second past it
        {OFF_HOME, 38'd253402293599, 1'b1, {14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 1'b0}},
        {OFF_HOME, 38'd253402293600, 1'b1, {14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1}},
        // zero offset: day edges and leap days
        {OFF_UTC,  38'd0,            1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        {OFF_UTC,  38'd86399,        1'b1, {14'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 1'b0}},
        {OFF_UTC,  38'd68169600,     1'b0, 35'd0},
        {OFF_UTC,  38'd951782400,    1'b1, {14'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 1'b0}},
        {OFF_UTC,  38'd951868800,    1'b0, 35'd0},
        {OFF_UTC,  38'd4107456000,   1'b0, 35'd0},
        {OFF_UTC,  38'd4107542400,   1'b0, 35'd0},
        {OFF_UTC,  38'd253402300799, 1'b1, {14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 1'b0}},
        {OFF_UTC,  38'h15_5555_5555, 1'b0, 35'd0},
        {OFF_UTC,  38'h2A_AAAA_AAAA, 1'b0, 35'd0},
        // most negative stated offset: clamp of negative local time
        {OFF_WEST, 38'd0,            1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        {OFF_WEST, 38'd43199,        1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        {OFF_WEST, 38'd43200,        1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        {OFF_WEST, 38'd43260,        1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd1, 1'b0}},
        // most positive stated offset: range limit
        {OFF_EAST, 38'd253402250399, 1'b1, {14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 1'b0}},
        {OFF_EAST, 38'd253402250400, 1'b1, {14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1}},
        // raw 17-bit extremes, taken as they stand
        {OFF_MIN,  38'd65535,        1'b1, {14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 1'b0}},
        {OFF_MIN,  38'h3F_FFFF_FFFF, 1'b0, 35'd0},
        {OFF_MAX,  38'd0,            1'b1, {14'd1970, 4'd1, 5'd1, 5'd18, 6'd12, 1'b0}},
        {OFF_MAX,  38'd253402235264, 1'b0, 35'd0}
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [ustc_pkg::OFFSET_W-1:0]     cfg_wr_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [ustc_pkg::TDATA_W-1:0]      s_tdata;   // [37:0] unix_seconds
    logic                              m_tvalid;
    logic                              m_tready;
    logic [ustc_pkg::TDATA_W-1:0]      m_tdata;   // [13:0] year, [17:14] month,
                                                  // [22:18] day_of_month,
                                                  // [27:23] hour, [33:28] minute
    logic                              m_tuser;   // [0] out_of_range

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [16:0] offset_shadow;     // offset the DUT holds right now
    civil_t      pending_dates[$];  // expected results, oldest first
    int          mismatch_count;
    bit          steady;            // suppress idling on both streams
    bit          hold_request;      // ask the receiver for one long hold-off
    bit          fixed_date_on;     // offered transfer carries a typed result
    civil_t      fixed_date;

    unix_seconds_to_calendar_top i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
        case (mo) inside
            2:           return is_leap(yr) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Local civil date and time of day for one Unix time under one offset
    function automatic civil_t civil_from_unix(input logic [37:0] secs,
                                               input logic [16:0] offset);
        longint          shifted;
        longint unsigned wall;
        int unsigned     days;
        int unsigned     sec_of_day;
        int unsigned     yr;
        int unsigned     mo;
        int unsigned     span;
        civil_t          c;
        shifted = longint'({26'd0, secs}) + longint'($signed(offset));
        // clamp negative local time to the epoch
        wall = (shifted < 0) ? 64'd0 : $unsigned(shifted);
        c = '0;
        sec_of_day = int'(wall % SECONDS_PER_DAY);
        c.hour     = 5'(sec_of_day / 3600);
        c.minute   = 6'((sec_of_day % 3600) / 60);
        if (wall >= YEAR_10000_SECS)
        begin
            c.oor = 1'b1;
        end
        else
        begin
            days = int'(wall / SECONDS_PER_DAY);
            yr   = 1970;
            while (days >= DAYS_PER_ERA)
            begin
                days -= DAYS_PER_ERA;
                yr   += 400;
            end
            span = is_leap(yr) ? 366 : 365;
            while (days >= span)
            begin
                days -= span;
                yr++;
                span = is_leap(yr) ? 366 : 365;
            end
            mo   = 1;
            span = month_length(yr, mo);
            while (days >= span && mo < 12)
            begin
                days -= span;
                mo++;
                span = month_length(yr, mo);
            end
            c.year  = 14'(yr);
            c.month = 4'(mo);
            c.day   = 5'(days + 1);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Random Unix times: raw 38-bit values, in-range values, times that land
    // near a year or leap-day edge, times near the year-10000 limit, and
    // small local times near the epoch, some of them just inside the clamp region
    // ------------------------------------------------------------------------
    function automatic logic [37:0] pick_unix_seconds();
        int unsigned shape;
        int unsigned yr;
        longint      days;
        longint      target;
        logic [37:0] raw;
        raw   = {6'($urandom), 32'($urandom)};
        shape = $urandom_range(99);
        if (shape < 25)
        begin
            return raw;
        end
        else if (shape < 50)
        begin
            return 38'(raw % YEAR_10000_SECS);
        end
        else
        begin
            if (shape < 80)
            begin
                // day count of January 1st of a random year, then step to
                // the end of February or the end of the year, or stay on January 1st
                yr   = $urandom_range(9999, 1971);
                days = longint'(365 * (yr - 1970) + (yr - 1) / 4 - (yr - 1) / 100
                                + (yr - 1) / 400 - 477);
                case ($urandom_range(3))
                    1:       days += 58;
                    2:       days += 59;
                    3:       days += 364;
                    default: days += 0;
                endcase
                target = days * 86400;
            end
            else if (shape < 90)
            begin
                target = longint'(YEAR_10000_SECS);
            end
            else
            begin
                target = longint'($urandom_range(100000));
            end
            // land the local time near the edge, not the UTC time
            target = target + longint'($urandom_range(240)) - 120
                     - longint'($signed(offset_shadow));
            if (target < 0)
                target = 0;
            return target[37:0];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking: push a prediction for every accepted input transfer and
    // compare every accepted result transfer against the oldest one
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        civil_t got;
        civil_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[13:0], m_tdata[17:14], m_tdata[22:18],
                       m_tdata[27:23], m_tdata[33:28], m_tuser};
                if (pending_dates.size() == 0)
                begin
                    $display("%0t: result transfer with nothing pending, got %h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    check_field("year",         32'(want.year),   32'(got.year));
                    check_field("month",        32'(want.month),  32'(got.month));
                    check_field("day_of_month", 32'(want.day),    32'(got.day));
                    check_field("hour",         32'(want.hour),   32'(got.hour));
                    check_field("minute",       32'(want.minute), 32'(got.minute));
                    check_field("out_of_range", 32'(want.oor),    32'(got.oor));
                end
            end
            if (s_tvalid && s_tready)
                pending_dates.push_back(fixed_date_on ? fixed_date
                                        : civil_from_unix(s_tdata[37:0], offset_shadow));
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one time on the input stream, with an optional idle cycle first;
    // return at the falling edge after the transfer.
    task automatic offer_time(input logic [37:0] secs, input bit pinned, input civil_t want);
        fixed_date_on = pinned;
        fixed_date    = want;
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, secs};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
    endtask

    // Drain the pipeline, then write a new offset while the block is idle
    task automatic write_offset(input logic [16:0] value);
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        offset_shadow  = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [16:0] next_offset;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        offset_shadow  = OFF_HOME;
        mismatch_count = 0;
        steady         = 1'b0;
        hold_request   = 1'b0;
        fixed_date_on  = 1'b0;
        fixed_date     = '0;

        // Hold reset, then release it away from the sampling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: the first rows run on the reset offset
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].offset != offset_shadow)
                write_offset(DIRECTED[i].offset);
            offer_time(DIRECTED[i].secs, DIRECTED[i].pinned, DIRECTED[i].want);
        end

        // Random phases: rotate through the offsets, with one phase free of
        // idling and one phase that opens with a long receiver hold-off
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 5)
                0:       next_offset = (ph == 0) ? OFF_WEST : OFF_MIN;
                1:       next_offset = (ph == 1) ? OFF_EAST : OFF_MAX;
                2:       next_offset = 17'($urandom_range(93600) - 43200);
                3:       next_offset = 17'($urandom);
                default: next_offset = (ph == 4) ? OFF_UTC : OFF_HOME;
            endcase
            write_offset(next_offset);
            steady = (ph == 3);
            if (ph == 6)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_time(pick_unix_seconds(), 1'b0, '0);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Wait for the last results, then let any stray transfer show up
        while (pending_dates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, none while steady, and one hold-off of
    // HOLD_CYCLES so the pipeline fills and stalls its input
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready    <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (!steady && $urandom_range(99) < IDLE_PERCENT)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end a hung run
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
